// File: rtl/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared sizes, order codes, book entry type and controller/datapath bundles.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int BOOK_DEPTH = 64;
  localparam int TAG_COUNT  = 1024;  // power of two: tags wrap by masking
  localparam int SLOT_W     = $clog2(BOOK_DEPTH);
  localparam int TIDX_W     = $clog2(TAG_COUNT);

  localparam int MODE_W  = 3;
  localparam int TAG_W   = 10;
  localparam int QTY_W   = 20;
  localparam int PRICE_W = 20;
  localparam int ARR_W   = 32;
  localparam int VAL_W   = 48;
  localparam int PROD_W  = QTY_W + PRICE_W;

  localparam logic [VAL_W-1:0] VALUE_MAX = {VAL_W{1'b1}};

  localparam logic [MODE_W-1:0] MODE_LIMIT_BUY   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LIMIT_SELL  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MARKET_BUY  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MARKET_SELL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CANCEL      = 3'd4;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [TAG_W-1:0]   tag;
    logic [ARR_W-1:0]   arr;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic clr_wr;     // clear one cancel flag
    logic load;       // take a request
    logic scan_init;  // restart best-entry scan
    logic scan;       // scan step
    logic drop;       // drop best entry
    logic fill;       // fill against best entry
    logic acc;        // accumulate value, write back best entry
    logic rest;       // rest remainder on own side
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_trade;
    logic scan_done;
    logic found;
    logic cancelled;
    logic price_worse;
    logic is_limit;
    logic qty_zero;
    logic best_empty;
  } sts_t;

  function automatic logic [TIDX_W-1:0] tag_index(input logic [TAG_W-1:0] t);
    return TIDX_W'(t % TAG_COUNT);
  endfunction

endpackage

// File: rtl/lobm_ram.sv
// ----------------------------------------------------------------------------
// lobm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/lobm_dp.sv
// ----------------------------------------------------------------------------
// lobm_dp
// Book storage, best-entry scan, fill arithmetic and result registers.
// ----------------------------------------------------------------------------
module lobm_dp import lobm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [MODE_W-1:0]  mode,
  input  logic [TAG_W-1:0]   order_id,
  input  logic [QTY_W-1:0]   quantity,
  input  logic [PRICE_W-1:0] price,
  output sts_t               sts,
  output logic [VAL_W-1:0]   traded_value,
  output logic               value_saturated,
  output logic               book_overflow
);

  logic [MODE_W-1:0]    mode_r;
  logic [TAG_W-1:0]     tag_r;
  logic [QTY_W-1:0]     qty_r;
  logic [PRICE_W-1:0]   price_r;
  logic [ARR_W-1:0]     arr_r;
  logic [ARR_W-1:0]     arr_cnt;
  logic [TIDX_W-1:0]    clr_idx;
  logic [SLOT_W:0]      scan_idx;
  logic                 rd_valid;
  logic [SLOT_W-1:0]    rd_slot;
  logic                 found;
  entry_t               best;
  logic [SLOT_W-1:0]    best_slot;
  logic [VAL_W-1:0]     total;
  logic                 sat;
  logic                 ovf;
  logic [PROD_W-1:0]    prod;
  logic [BOOK_DEPTH-1:0] bid_occ;
  logic [BOOK_DEPTH-1:0] ask_occ;

  logic                 is_buy;
  logic                 is_limit;
  entry_t               bid_rdata;
  entry_t               ask_rdata;
  entry_t               cand;
  logic [BOOK_DEPTH-1:0] opp_occ;
  logic [BOOK_DEPTH-1:0] own_occ;
  logic                 cand_ok;
  logic                 better;
  logic [QTY_W-1:0]     fill_qty;
  logic [VAL_W:0]       sum;
  logic                 free_ok;
  logic [SLOT_W-1:0]    free_slot;
  entry_t               rest_entry;
  entry_t               wb_entry;
  logic                 bid_we;
  logic                 ask_we;
  logic [SLOT_W-1:0]    bid_waddr;
  logic [SLOT_W-1:0]    ask_waddr;
  entry_t               bid_wdata;
  entry_t               ask_wdata;
  logic                 can_we;
  logic [TIDX_W-1:0]    can_waddr;
  logic                 can_rdata;

  assign is_buy   = (mode_r == MODE_LIMIT_BUY) || (mode_r == MODE_MARKET_BUY);
  assign is_limit = (mode_r == MODE_LIMIT_BUY) || (mode_r == MODE_LIMIT_SELL);
  assign cand     = is_buy ? ask_rdata : bid_rdata;
  assign opp_occ  = is_buy ? ask_occ : bid_occ;
  assign own_occ  = is_buy ? bid_occ : ask_occ;
  assign cand_ok  = rd_valid && opp_occ[rd_slot];

  always_comb begin
    if (!found) begin
      better = 1'b1;
    end else if (cand.price != best.price) begin
      better = is_buy ? (cand.price < best.price) : (cand.price > best.price);
    end else begin
      better = cand.arr < best.arr;
    end
  end

  assign fill_qty = (qty_r < best.qty) ? qty_r : best.qty;
  assign sum      = {1'b0, total} + (VAL_W+1)'(prod);

  // first free slot on the own side
  always_comb begin
    free_ok   = 1'b0;
    free_slot = '0;
    for (int i = 0; i < BOOK_DEPTH; i++) begin
      if (!free_ok && !own_occ[i]) begin
        free_ok   = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  assign rest_entry = '{price: price_r, qty: qty_r, tag: tag_r, arr: arr_r};
  assign wb_entry   = best;

  assign bid_we    = (cmd.acc && !is_buy) || (cmd.rest && is_buy && free_ok);
  assign ask_we    = (cmd.acc && is_buy) || (cmd.rest && !is_buy && free_ok);
  assign bid_waddr = cmd.rest ? free_slot : best_slot;
  assign ask_waddr = cmd.rest ? free_slot : best_slot;
  assign bid_wdata = cmd.rest ? rest_entry : wb_entry;
  assign ask_wdata = cmd.rest ? rest_entry : wb_entry;

  assign can_we    = cmd.clr_wr || (cmd.load && (mode == MODE_CANCEL));
  assign can_waddr = cmd.clr_wr ? clr_idx : tag_index(order_id);

  lobm_ram #(.WIDTH(ENTRY_W), .DEPTH(BOOK_DEPTH)) u_bid_ram (
    .clk   (clk),
    .we    (bid_we),
    .waddr (bid_waddr),
    .wdata (bid_wdata),
    .raddr (scan_idx[SLOT_W-1:0]),
    .rdata (bid_rdata)
  );

  lobm_ram #(.WIDTH(ENTRY_W), .DEPTH(BOOK_DEPTH)) u_ask_ram (
    .clk   (clk),
    .we    (ask_we),
    .waddr (ask_waddr),
    .wdata (ask_wdata),
    .raddr (scan_idx[SLOT_W-1:0]),
    .rdata (ask_rdata)
  );

  lobm_ram #(.WIDTH(1), .DEPTH(TAG_COUNT)) u_cancel_ram (
    .clk   (clk),
    .we    (can_we),
    .waddr (can_waddr),
    .wdata (!cmd.clr_wr),
    .raddr (tag_index(best.tag)),
    .rdata (can_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx  <= '0;
      arr_cnt  <= '0;
      bid_occ  <= '0;
      ask_occ  <= '0;
      rd_valid <= 1'b0;
      found    <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (cmd.load) begin
        mode_r  <= mode;
        tag_r   <= order_id;
        qty_r   <= quantity;
        price_r <= price;
        arr_r   <= arr_cnt;
        arr_cnt <= arr_cnt + 1'b1;
        total   <= '0;
        sat     <= 1'b0;
        ovf     <= 1'b0;
      end
      if (cmd.load || cmd.scan_init) begin
        scan_idx <= '0;
        rd_valid <= 1'b0;
        found    <= 1'b0;
      end else if (cmd.scan) begin
        // issue the next slot, compare the one read last cycle
        rd_valid <= !scan_idx[SLOT_W];
        rd_slot  <= scan_idx[SLOT_W-1:0];
        if (!scan_idx[SLOT_W]) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (cand_ok && better) begin
          found     <= 1'b1;
          best      <= cand;
          best_slot <= rd_slot;
        end
      end
      if (cmd.drop) begin
        if (is_buy) ask_occ[best_slot] <= 1'b0;
        else        bid_occ[best_slot] <= 1'b0;
      end
      if (cmd.fill) begin
        qty_r    <= qty_r - fill_qty;
        best.qty <= best.qty - fill_qty;
        prod     <= PROD_W'(fill_qty) * PROD_W'(best.price);
      end
      if (cmd.acc) begin
        if (sum >= (VAL_W+1)'(VALUE_MAX)) begin
          total <= VALUE_MAX;
          sat   <= 1'b1;
        end else begin
          total <= sum[VAL_W-1:0];
        end
        if (best.qty == '0) begin
          if (is_buy) ask_occ[best_slot] <= 1'b0;
          else        bid_occ[best_slot] <= 1'b0;
        end
      end
      if (cmd.rest) begin
        if (free_ok) begin
          if (is_buy) bid_occ[free_slot] <= 1'b1;
          else        ask_occ[free_slot] <= 1'b1;
        end else begin
          ovf <= 1'b1;
        end
      end
    end
  end

  assign sts.clr_last    = (clr_idx == TIDX_W'(TAG_COUNT - 1));
  assign sts.in_trade    = (mode == MODE_LIMIT_BUY) || (mode == MODE_LIMIT_SELL) ||
                           (mode == MODE_MARKET_BUY) || (mode == MODE_MARKET_SELL);
  assign sts.scan_done   = rd_valid && (rd_slot == SLOT_W'(BOOK_DEPTH - 1));
  assign sts.found       = found;
  assign sts.cancelled   = can_rdata;
  assign sts.price_worse = is_buy ? (best.price > price_r) : (best.price < price_r);
  assign sts.is_limit    = is_limit;
  assign sts.qty_zero    = (qty_r == '0);
  assign sts.best_empty  = (best.qty == '0);

  assign traded_value    = total;
  assign value_saturated = sat;
  assign book_overflow   = ovf;

endmodule

// File: rtl/lobm_ctrl.sv
// ----------------------------------------------------------------------------
// lobm_ctrl
// Sequencer: clear pass, request intake, book walk, resting, result strobe.
// ----------------------------------------------------------------------------
module lobm_ctrl import lobm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic done
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_EVAL = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_REST = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       want_rest;

  assign want_rest = sts.is_limit && !sts.qty_zero;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (sts.in_trade) state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (!sts.found) begin
          state_next = want_rest ? S_REST : S_DONE;
        end else begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        priority if (sts.cancelled) begin
          cmd.drop      = 1'b1;
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end else if (sts.is_limit && sts.price_worse) begin
          state_next = want_rest ? S_REST : S_DONE;
        end else begin
          cmd.fill   = 1'b1;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sts.best_empty) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_REST: begin
        cmd.rest   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// File: rtl/limit_order_book_matcher_unit.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit
// Price-time priority matcher over a bid book and an ask book.
// ----------------------------------------------------------------------------
// Usage:
//   Drive mode, order_id, quantity and price and raise start; the request is
//   taken at the edge where start is high and busy is low.
//   Orders (modes 0..3) give one result: traded_value, value_saturated and
//   book_overflow are valid for the single cycle in which done is high.
//   Cancels and unused modes give no result and leave busy low.
//   Each step of the book walk scans all book slots through the entry RAM
//   read port, then reads the cancel flag of the best entry, checks it and
//   issues the fill, and then accumulates the value. A cancelled entry is
//   dropped and the walk starts a new scan, as it does after a fill that
//   empties an entry. The walk ends on an empty side, on a worse price, or
//   right after a partial fill; a limit order with quantity left then rests,
//   and done is high in the cycle after that. After reset the cancel flags
//   are cleared one per cycle while busy stays high, and both books start
//   empty. Results cannot be held off; done pulses once per order.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_unit import lobm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MODE_W-1:0]  mode,
  input  logic [TAG_W-1:0]   order_id,
  input  logic [QTY_W-1:0]   quantity,
  input  logic [PRICE_W-1:0] price,
  output logic               busy,
  output logic               done,
  output logic [VAL_W-1:0]   traded_value,
  output logic               value_saturated,
  output logic               book_overflow
);

  cmd_t cmd;
  sts_t sts;

  lobm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  lobm_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .mode            (mode),
    .order_id        (order_id),
    .quantity        (quantity),
    .price           (price),
    .sts             (sts),
    .traded_value    (traded_value),
    .value_saturated (value_saturated),
    .book_overflow   (book_overflow)
  );

`ifndef ASSERT_OFF
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_cancel_quiet: assert property (@(posedge clk) disable iff (rst)
      (start && !busy && mode == MODE_CANCEL) |=> (!done && !busy))
    else $error("cancel request produced a result");
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
      (done && value_saturated) |-> (traded_value == VALUE_MAX))
    else $error("saturation flag without maximum value");
`endif

endmodule

// File: tb/limit_order_book_matcher_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit_tb
// Drives limit, market, cancel and spare-mode requests into the matcher,
// predicts every fill total from a software book kept beside it, and compares
// each strobed result field by field in arrival order.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_unit_tb;
  import lobm_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam int SIDE_BID = 0;
  localparam int SIDE_ASK = 1;
  localparam int RANDOM_ORDERS = 1930;
  localparam int CALM_TAIL = 200;
  localparam longint CYCLE_LIMIT = 12_000_000;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic             sat;
    logic             ovf;
  } fill_report_t;

  typedef struct {
    logic [MODE_W-1:0]  m;
    logic [TAG_W-1:0]   id;
    logic [QTY_W-1:0]   q;
    logic [PRICE_W-1:0] p;
    bit                 typed;
    logic [VAL_W-1:0]   value;
  } order_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [MODE_W-1:0]  mode = '0;
  logic [TAG_W-1:0]   order_id = '0;
  logic [QTY_W-1:0]   quantity = '0;
  logic [PRICE_W-1:0] price = '0;
  logic               busy;
  logic               done;
  logic [VAL_W-1:0]   traded_value;
  logic               value_saturated;
  logic               book_overflow;

  limit_order_book_matcher_unit dut (
    .clk(clk), .rst(rst), .start(start), .mode(mode), .order_id(order_id),
    .quantity(quantity), .price(price), .busy(busy), .done(done),
    .traded_value(traded_value), .value_saturated(value_saturated),
    .book_overflow(book_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // software copy of both books
  logic [PRICE_W-1:0] bk_price [2][BOOK_DEPTH];
  logic [QTY_W-1:0]   bk_qty   [2][BOOK_DEPTH];
  logic [TAG_W-1:0]   bk_tag   [2][BOOK_DEPTH];
  logic [ARR_W-1:0]   bk_arr   [2][BOOK_DEPTH];
  bit                 bk_live  [2][BOOK_DEPTH];
  bit                 tag_dead [TAG_COUNT];
  logic [ARR_W-1:0]   arrivals = '0;

  fill_report_t expected_fills[$];
  order_row_t   pending_rows[$];
  int           errors = 0;
  longint       cycles = 0;

  function automatic int best_entry(int s, bit want_high);
    int b;
    b = -1;
    for (int i = 0; i < BOOK_DEPTH; i++) begin
      if (!bk_live[s][i]) continue;
      if (b < 0) b = i;
      else if (bk_price[s][i] != bk_price[s][b]) begin
        if (want_high ? (bk_price[s][i] > bk_price[s][b])
                      : (bk_price[s][i] < bk_price[s][b])) b = i;
      end else if (bk_arr[s][i] < bk_arr[s][b]) b = i;
    end
    return b;
  endfunction

  // returns 1 when the request yields a result
  function automatic bit match_order(input order_row_t r, output fill_report_t res);
    logic [ARR_W-1:0] arr;
    bit buy, lim, want_rest, placed;
    int opp, own, b;
    logic [QTY_W-1:0] left, fq;
    logic [63:0] total;
    arr = arrivals;
    arrivals = arrivals + 1;
    res = '{'0, 1'b0, 1'b0};
    if (r.m == MODE_CANCEL) begin
      tag_dead[r.id % TAG_COUNT] = 1'b1;
      return 1'b0;
    end
    if (r.m > MODE_CANCEL) return 1'b0;
    buy = (r.m == MODE_LIMIT_BUY) || (r.m == MODE_MARKET_BUY);
    lim = (r.m == MODE_LIMIT_BUY) || (r.m == MODE_LIMIT_SELL);
    opp = buy ? SIDE_ASK : SIDE_BID;
    own = buy ? SIDE_BID : SIDE_ASK;
    left = r.q;
    total = '0;
    want_rest = 1'b0;
    forever begin
      b = best_entry(opp, !buy);
      if (b < 0) begin
        want_rest = lim && left != 0;
        break;
      end
      if (tag_dead[bk_tag[opp][b] % TAG_COUNT]) begin
        bk_live[opp][b] = 1'b0;
        continue;
      end
      if (lim && (buy ? (bk_price[opp][b] > r.p) : (bk_price[opp][b] < r.p))) begin
        want_rest = left != 0;
        break;
      end
      fq = (left < bk_qty[opp][b]) ? left : bk_qty[opp][b];
      left -= fq;
      bk_qty[opp][b] -= fq;
      total += 64'(fq) * 64'(bk_price[opp][b]);
      if (total >= 64'(VALUE_MAX)) begin
        total = 64'(VALUE_MAX);
        res.sat = 1'b1;
      end
      if (bk_qty[opp][b] != 0) break;
      bk_live[opp][b] = 1'b0;
    end
    if (want_rest) begin
      placed = 1'b0;
      for (int i = 0; i < BOOK_DEPTH && !placed; i++) begin
        if (!bk_live[own][i]) begin
          bk_live[own][i] = 1'b1;
          bk_price[own][i] = r.p;
          bk_qty[own][i] = left;
          bk_tag[own][i] = r.id;
          bk_arr[own][i] = arr;
          placed = 1'b1;
        end
      end
      res.ovf = !placed;
    end
    res.value = total[VAL_W-1:0];
    return 1'b1;
  endfunction

  task automatic report(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    $display("mismatch on %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  // check the strobed result first, then log the request taken at this edge
  always @(posedge clk) begin
    fill_report_t exp_r, pred;
    order_row_t r;
    if (!rst) begin
      cycles++;
      if (done) begin
        if (expected_fills.size() == 0) begin
          report("unexpected result", traded_value, '0);
        end else begin
          exp_r = expected_fills.pop_front();
          if (traded_value !== exp_r.value) report("traded_value", traded_value, exp_r.value);
          if (value_saturated !== exp_r.sat)
            report("value_saturated", VAL_W'(value_saturated), VAL_W'(exp_r.sat));
          if (book_overflow !== exp_r.ovf)
            report("book_overflow", VAL_W'(book_overflow), VAL_W'(exp_r.ovf));
        end
      end
      if (start && !busy) begin
        r = pending_rows.pop_front();
        if (match_order(r, pred)) begin
          if (r.typed && pred.value != r.value) report("typed total", pred.value, r.value);
          if (r.typed) pred.value = r.value;
          expected_fills.push_back(pred);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("limit_order_book_matcher_unit_tb NOT OK");
      $finish;
    end
  end

  task automatic send(order_row_t r, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pending_rows.push_back(r);
    start <= 1'b1;
    mode <= r.m;
    order_id <= r.id;
    quantity <= r.q;
    price <= r.p;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [MODE_W-1:0] MODE_TYPE_SPARE(int pick);
    return (pick[0]) ? MODE_SPARE_HI : MODE_SPARE_LO + MODE_W'(pick[1]);
  endfunction

  function automatic order_row_t random_order(bit flood);
    order_row_t r;
    int pick;
    r.typed = 1'b0;
    r.value = '0;
    r.id = TAG_W'($urandom_range(0, 1023));
    pick = $urandom_range(0, 99);
    if (flood) r.m = MODE_LIMIT_BUY;
    else if (pick < 35) r.m = MODE_LIMIT_BUY;
    else if (pick < 70) r.m = MODE_LIMIT_SELL;
    else if (pick < 80) r.m = MODE_MARKET_BUY;
    else if (pick < 90) r.m = MODE_MARKET_SELL;
    else if (pick < 96) r.m = MODE_CANCEL;
    else r.m = MODE_TYPE_SPARE(pick);
    pick = $urandom_range(0, 99);
    if (pick < 3) r.q = '0;
    else if (pick < 8) r.q = QTY_W'($urandom());
    else if (pick < 10) r.q = '1;
    else r.q = QTY_W'($urandom_range(1, 60));
    pick = $urandom_range(0, 99);
    if (flood) r.p = PRICE_W'($urandom_range(1, 20));
    else if (pick < 5) r.p = PRICE_W'($urandom());
    else if (pick < 7) r.p = (pick == 5) ? '0 : '1;
    else r.p = PRICE_W'($urandom_range(1000, 1030));
    return r;
  endfunction

  order_row_t directed[] = '{
    '{MODE_LIMIT_BUY,   10'd0,    20'd0,      20'd5,      1'b1, 48'd0},
    '{MODE_MARKET_SELL, 10'd1,    20'd100,    20'd0,      1'b1, 48'd0},
    '{MODE_SPARE_LO,    10'd2,    20'd7,      20'd7,      1'b0, 48'd0},
    '{MODE_SPARE_HI,    10'd1023, 20'hFFFFF,  20'hFFFFF,  1'b0, 48'd0},
    '{MODE_LIMIT_SELL,  10'd10,   20'd10,     20'd100,    1'b1, 48'd0},
    '{MODE_LIMIT_SELL,  10'd11,   20'd5,      20'd90,     1'b1, 48'd0},
    '{MODE_LIMIT_BUY,   10'd12,   20'd7,      20'd95,     1'b1, 48'd450},
    '{MODE_MARKET_SELL, 10'd13,   20'd3,      20'd0,      1'b1, 48'd190},
    '{MODE_CANCEL,      10'd10,   20'd0,      20'd0,      1'b0, 48'd0},
    '{MODE_MARKET_BUY,  10'd14,   20'd50,     20'd0,      1'b1, 48'd0},
    '{MODE_LIMIT_SELL,  10'd15,   20'd20,     20'd200,    1'b0, 48'd0},
    '{MODE_LIMIT_SELL,  10'd16,   20'd20,     20'd200,    1'b0, 48'd0},
    '{MODE_LIMIT_BUY,   10'd17,   20'd0,      20'd300,    1'b0, 48'd0},
    '{MODE_LIMIT_BUY,   10'd18,   20'd20,     20'd200,    1'b0, 48'd0},
    '{MODE_LIMIT_SELL,  10'd1023, 20'hFFFFF,  20'hFFFFF,  1'b0, 48'd0},
    '{MODE_MARKET_BUY,  10'd19,   20'hFFFFF,  20'd0,      1'b0, 48'd0},
    '{MODE_LIMIT_BUY,   10'd20,   20'd1,      20'd0,      1'b0, 48'd0},
    '{MODE_MARKET_SELL, 10'd21,   20'hFFFFF,  20'hFFFFF,  1'b0, 48'd0},
    '{MODE_CANCEL,      10'd1023, 20'hFFFFF,  20'hFFFFF,  1'b0, 48'd0}
  };

  initial begin
    int gap;
    bit flood;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send(directed[i], ($urandom_range(0, 2) == 0) ? 1 : 0);
    for (int n = 0; n < RANDOM_ORDERS; n++) begin
      // fill the bid side past its depth once to force overflow
      flood = (n >= 600 && n < 680);
      if (n == 900) begin
        start <= 1'b0;
        // let the last accepted request reach the expected queue
        @(posedge clk);
        while (expected_fills.size() != 0) @(posedge clk);
      end
      gap = 0;
      if (n < RANDOM_ORDERS - CALM_TAIL && $urandom_range(0, 3) == 0)
        gap = $urandom_range(1, 14);
      send(random_order(flood), gap);
    end
    start <= 1'b0;
    @(posedge clk);
    while (expected_fills.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_fills.size() == 0) begin
      $display("limit_order_book_matcher_unit_tb OK");
    end else begin
      $display("limit_order_book_matcher_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/lobm_pkg.sv
rtl/lobm_ram.sv
rtl/lobm_dp.sv
rtl/lobm_ctrl.sv
rtl/limit_order_book_matcher_unit.sv
tb/limit_order_book_matcher_unit_tb.sv
